// ===== rtl/shs_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// shs_pkg
// Constants and round functions shared by the SHA-256 stream hasher core.
// ----------------------------------------------------------------------------
package shs_pkg;

    localparam int unsigned WORD_W      = 32;
    localparam int unsigned HASH_WORDS  = 8;
    localparam int unsigned BLOCK_WORDS = 16;
    localparam int unsigned ROUNDS      = 64;
    localparam int unsigned TDATA_W     = 40;

    localparam logic [WORD_W-1:0] PAD_MARKER_WORD = 32'h8000_0000;

    localparam logic [WORD_W-1:0] INIT_HASH [HASH_WORDS] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    function automatic logic [WORD_W-1:0] round_const(input logic [5:0] idx);
        logic [WORD_W-1:0] k;
        case (idx)
            6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
            default: k = '0;
        endcase
        return k;
    endfunction

    function automatic logic [WORD_W-1:0] rotr(input logic [WORD_W-1:0] x,
                                               input int unsigned n);
        return (x >> n) | (x << (WORD_W - n));
    endfunction

    function automatic logic [WORD_W-1:0] big_sigma0(input logic [WORD_W-1:0] x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [WORD_W-1:0] big_sigma1(input logic [WORD_W-1:0] x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [WORD_W-1:0] small_sigma0(input logic [WORD_W-1:0] x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [WORD_W-1:0] small_sigma1(input logic [WORD_W-1:0] x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic logic [WORD_W-1:0] choose(input logic [WORD_W-1:0] e,
                                                 input logic [WORD_W-1:0] f,
                                                 input logic [WORD_W-1:0] g);
        return (e & f) ^ (~e & g);
    endfunction

    function automatic logic [WORD_W-1:0] majority(input logic [WORD_W-1:0] a,
                                                   input logic [WORD_W-1:0] b,
                                                   input logic [WORD_W-1:0] c);
        return (a & b) ^ (a & c) ^ (b & c);
    endfunction

endpackage
`default_nettype wire

// ===== rtl/sha256_stream_hasher_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sha256_stream_hasher_core
// SHA-256 digest of a byte message streamed in as big-endian 32-bit words.
// ----------------------------------------------------------------------------
// Usage: message words enter on the s_ channel, first byte in bits 31..24.
// Every item is a full word except the one marked by s_tlast, whose
// byte_count gives 0 to 4 valid leading bytes (5 to 7 count as 4). After the
// last item the core appends the 0x80 marker, zero padding and the 64-bit
// bit length, then delivers the eight digest words on the m_ channel, word 0
// (most significant) first, with m_tlast on word 7.
// Timing: a word that does not complete a block is accepted directly. The
// word that fills the sixteenth slot starts a compression: the 64 rounds of
// the single round unit (one round per cycle), then a fold of the working
// variables into the chaining hash; s_tready stays low through both. On the
// last item, padding words are written one per cycle and one or two final
// compressions follow; the first digest word then appears, and each further
// word is offered in the cycle after the previous one is taken.
// While digest words are offered no input is accepted; a stalled receiver
// simply holds the core with m_tdata steady. After word 7 is taken the core
// returns to its reset state, ready for the next message. Reset
// (aresetn low, synchronous) loads the initial hash and empties the block.
// ----------------------------------------------------------------------------
module sha256_stream_hasher_core (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    // s_tdata: data_word [31:0], byte_count [34:32], zero fill [39:35]
    input  wire logic [shs_pkg::TDATA_W-1:0] s_tdata,
    input  wire logic                       s_tlast,
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    // m_tdata: digest_word [31:0], word_index [34:32], zero fill [39:35]
    output logic [shs_pkg::TDATA_W-1:0]     m_tdata,
    output logic                            m_tlast,
    output logic                            m_tvalid,
    input  wire logic                       m_tready
);
    import shs_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_ROUND,
        ST_ADD,
        ST_EMIT
    } state_t;

    typedef logic [WORD_W-1:0] word_t;

    state_t      state_reg, state_next;
    word_t       chain_reg [HASH_WORDS];
    word_t       chain_next [HASH_WORDS];
    word_t       work_reg [HASH_WORDS];
    word_t       work_next [HASH_WORDS];
    word_t       blk_reg [BLOCK_WORDS];
    word_t       blk_next [BLOCK_WORDS];
    logic [3:0]  wib_reg, wib_next;
    logic [63:0] bits_reg, bits_next;
    logic [5:0]  rnd_reg, rnd_next;
    logic [2:0]  idx_reg, idx_next;
    logic        pad_reg, pad_next;
    logic        marker_reg, marker_next;
    logic        len_hi_reg, len_hi_next;
    logic        final_reg, final_next;

    logic        push_en;
    word_t       push_word;
    logic [2:0]  cnt_sat;
    word_t       in_word;
    word_t       tail_word;
    word_t       t1, t2, sched_word;

    assign in_word = s_tdata[WORD_W-1:0];
    assign cnt_sat = (s_tdata[34:32] > 3'd4) ? 3'd4 : s_tdata[34:32];

    // Keep the valid leading bytes and place the 0x80 marker right after them.
    always_comb begin
        case (cnt_sat)
            3'd0:    tail_word = PAD_MARKER_WORD;
            3'd1:    tail_word = {in_word[31:24], 24'h80_0000};
            3'd2:    tail_word = {in_word[31:16], 16'h8000};
            3'd3:    tail_word = {in_word[31:8], 8'h80};
            default: tail_word = in_word;
        endcase
    end

    // The shared round unit. The block buffer is a shift line: the current
    // schedule word sits in slot 0 and the word sixteen rounds ahead is
    // formed from fixed taps and shifted in at slot 15.
    assign t1 = work_reg[7] + big_sigma1(work_reg[4])
              + choose(work_reg[4], work_reg[5], work_reg[6])
              + round_const(rnd_reg) + blk_reg[0];
    assign t2 = big_sigma0(work_reg[0]) + majority(work_reg[0], work_reg[1], work_reg[2]);
    assign sched_word = small_sigma1(blk_reg[14]) + blk_reg[9]
                      + small_sigma0(blk_reg[1]) + blk_reg[0];

    always_comb begin
        state_next  = state_reg;
        chain_next  = chain_reg;
        work_next   = work_reg;
        blk_next    = blk_reg;
        wib_next    = wib_reg;
        bits_next   = bits_reg;
        rnd_next    = rnd_reg;
        idx_next    = idx_reg;
        pad_next    = pad_reg;
        marker_next = marker_reg;
        len_hi_next = len_hi_reg;
        final_next  = final_reg;
        push_en     = 1'b0;
        push_word   = '0;

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    push_en = 1'b1;
                    if (!s_tlast) begin
                        push_word = in_word;
                        bits_next = bits_reg + 64'd32;
                    end else begin
                        // A full last word still needs the marker in a word of its own.
                        push_word   = tail_word;
                        marker_next = (cnt_sat == 3'd4);
                        bits_next   = bits_reg + {58'd0, cnt_sat, 3'b000};
                        pad_next    = 1'b1;
                        state_next  = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                push_en = 1'b1;
                if (marker_reg) begin
                    push_word   = PAD_MARKER_WORD;
                    marker_next = 1'b0;
                end else if (len_hi_reg) begin
                    push_word   = bits_reg[31:0];
                    len_hi_next = 1'b0;
                    final_next  = 1'b1;
                end else if (wib_reg == 4'd14) begin
                    push_word   = bits_reg[63:32];
                    len_hi_next = 1'b1;
                end else begin
                    push_word = '0;
                end
            end
            ST_ROUND: begin
                for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
                    blk_next[i] = blk_reg[i+1];
                end
                blk_next[BLOCK_WORDS-1] = sched_word;
                work_next[7] = work_reg[6];
                work_next[6] = work_reg[5];
                work_next[5] = work_reg[4];
                work_next[4] = work_reg[3] + t1;
                work_next[3] = work_reg[2];
                work_next[2] = work_reg[1];
                work_next[1] = work_reg[0];
                work_next[0] = t1 + t2;
                rnd_next     = rnd_reg + 6'd1;
                if (rnd_reg == 6'(ROUNDS - 1)) begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD: begin
                for (int i = 0; i < HASH_WORDS; i++) begin
                    chain_next[i] = chain_reg[i] + work_reg[i];
                end
                if (final_reg) begin
                    idx_next   = 3'd0;
                    state_next = ST_EMIT;
                end else if (pad_reg) begin
                    state_next = ST_PAD;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_EMIT: begin
                if (m_tready) begin
                    if (idx_reg == 3'(HASH_WORDS - 1)) begin
                        chain_next = INIT_HASH;
                        wib_next   = 4'd0;
                        bits_next  = '0;
                        pad_next   = 1'b0;
                        final_next = 1'b0;
                        state_next = ST_IDLE;
                    end else begin
                        idx_next = idx_reg + 3'd1;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // Block write port; the sixteenth word starts a compression.
        if (push_en) begin
            blk_next[wib_reg] = push_word;
            if (wib_reg == 4'(BLOCK_WORDS - 1)) begin
                wib_next   = 4'd0;
                rnd_next   = 6'd0;
                work_next  = chain_reg;
                state_next = ST_ROUND;
            end else begin
                wib_next = wib_reg + 4'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        blk_reg  <= blk_next;
        work_reg <= work_next;
        rnd_reg  <= rnd_next;
        idx_reg  <= idx_next;
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            chain_reg  <= INIT_HASH;
            wib_reg    <= 4'd0;
            bits_reg   <= '0;
            pad_reg    <= 1'b0;
            marker_reg <= 1'b0;
            len_hi_reg <= 1'b0;
            final_reg  <= 1'b0;
        end else begin
            state_reg  <= state_next;
            chain_reg  <= chain_next;
            wib_reg    <= wib_next;
            bits_reg   <= bits_next;
            pad_reg    <= pad_next;
            marker_reg <= marker_next;
            len_hi_reg <= len_hi_next;
            final_reg  <= final_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_EMIT);
    assign m_tdata  = {5'd0, idx_reg, chain_reg[idx_reg]};
    assign m_tlast  = (idx_reg == 3'(HASH_WORDS - 1));

`ifndef SYNTH
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input accepted while digest words are pending");

    a_block_full_stalls: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && wib_reg == 4'd15) |=> (state_reg == ST_ROUND))
        else $error("full block did not start a compression");

    a_round_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ROUND && rnd_reg == 6'd63) |=> (state_reg == ST_ADD))
        else $error("compression did not end after 64 rounds");

    a_digest_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast) |=> (s_tready && wib_reg == 4'd0
                                               && bits_reg == 64'd0))
        else $error("core not back to its initial state after the digest");

    a_last_starts_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tlast) |=> pad_reg)
        else $error("last item did not start padding");
`endif

endmodule
`default_nettype wire

// ===== tb/sha256_stream_hasher_core_test.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sha256_stream_hasher_core_test
// Self-checking testbench for the SHA-256 stream hasher core.
// ----------------------------------------------------------------------------
// Messages are streamed into the core as 32-bit words. A software SHA-256
// inside the bench follows every accepted item and queues the eight digest
// words that each final item must produce. A monitor compares every digest
// word taken from the core against the oldest queued word. The run starts
// with hand-picked messages covering tail byte counts, saturation, empty and
// padding-overflow messages. Random messages then follow under several
// flow-control patterns, one of which holds the result side off for a long
// stretch so that the core backs up into its input.
// ----------------------------------------------------------------------------
module sha256_stream_hasher_core_test;

    typedef struct packed {
        logic [31:0] data_word;
        logic [2:0]  byte_count;
        logic        last_item;
    } msg_word_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } digest_word_t;

    typedef enum logic [2:0] {
        PH_STEADY,
        PH_SENDER_GAPS,
        PH_RECEIVER_STALLS,
        PH_BOTH_IDLE,
        PH_LONG_HOLD
    } idle_phase_t;

    localparam int unsigned CYCLE_LIMIT   = 400_000;
    localparam int unsigned LONG_HOLD     = 500;
    localparam int unsigned END_SETTLE    = 200;
    localparam int unsigned PHASE_ITEMS   = 60;
    localparam logic [31:0] MARKER_WORD   = 32'h8000_0000;

    localparam idle_phase_t RANDOM_PHASES [5] = '{
        PH_STEADY, PH_SENDER_GAPS, PH_RECEIVER_STALLS, PH_BOTH_IDLE, PH_LONG_HOLD
    };

    localparam logic [31:0] HASH_SEED [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
        32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
        32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
        32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
        32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    logic                        aclk     = 1'b0;
    logic                        aresetn  = 1'b0;
    logic [shs_pkg::TDATA_W-1:0] s_tdata  = '0;
    logic                        s_tlast  = 1'b0;
    logic                        s_tvalid = 1'b0;
    logic                        s_tready;
    logic [shs_pkg::TDATA_W-1:0] m_tdata;
    logic                        m_tlast;
    logic                        m_tvalid;
    logic                        m_tready = 1'b0;

    msg_word_t    pending_words [$];
    digest_word_t expected_digest [$];
    msg_word_t    offered_word;
    idle_phase_t  idle_phase  = PH_STEADY;
    int unsigned  cycle_count = 0;
    int unsigned  hold_left   = 0;
    logic         hold_used   = 1'b0;
    int           fail_count  = 0;

    // Bench copy of the hasher state.
    logic [31:0] hash_chain [8];
    logic [31:0] block_words [16];
    int          block_fill;
    logic [63:0] message_len_bits;

    sha256_stream_hasher_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Digest predictor
    // ------------------------------------------------------------------
    function automatic logic [31:0] rot_right(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic void restart_hasher();
        hash_chain       = HASH_SEED;
        block_fill       = 0;
        message_len_bits = '0;
    endfunction

    function automatic void compress_block();
        logic [31:0] sched [64];
        logic [31:0] va, vb, vc, vd, ve, vf, vg, vh;
        logic [31:0] t1, t2, s0, s1;
        int          i;
        for (i = 0; i < 16; i++) sched[i] = block_words[i];
        for (i = 16; i < 64; i++) begin
            s0 = rot_right(sched[i-15], 7) ^ rot_right(sched[i-15], 18) ^ (sched[i-15] >> 3);
            s1 = rot_right(sched[i-2], 17) ^ rot_right(sched[i-2], 19) ^ (sched[i-2] >> 10);
            sched[i] = s1 + sched[i-7] + s0 + sched[i-16];
        end
        va = hash_chain[0]; vb = hash_chain[1]; vc = hash_chain[2]; vd = hash_chain[3];
        ve = hash_chain[4]; vf = hash_chain[5]; vg = hash_chain[6]; vh = hash_chain[7];
        for (i = 0; i < 64; i++) begin
            t1 = vh + (rot_right(ve, 6) ^ rot_right(ve, 11) ^ rot_right(ve, 25))
                 + ((ve & vf) ^ (~ve & vg)) + ROUND_K[i] + sched[i];
            t2 = (rot_right(va, 2) ^ rot_right(va, 13) ^ rot_right(va, 22))
                 + ((va & vb) ^ (va & vc) ^ (vb & vc));
            vh = vg; vg = vf; vf = ve;
            ve = vd + t1;
            vd = vc; vc = vb; vb = va;
            va = t1 + t2;
        end
        hash_chain[0] += va; hash_chain[1] += vb; hash_chain[2] += vc; hash_chain[3] += vd;
        hash_chain[4] += ve; hash_chain[5] += vf; hash_chain[6] += vg; hash_chain[7] += vh;
    endfunction

    function automatic void absorb_word(input logic [31:0] w);
        block_words[block_fill] = w;
        block_fill++;
        if (block_fill == 16) begin
            compress_block();
            block_fill = 0;
        end
    endfunction

    // Follows one accepted item; a final item queues the eight digest words.
    function automatic void hash_item(input msg_word_t it);
        int          nbytes;
        logic [31:0] keep;
        int          i;
        if (!it.last_item) begin
            message_len_bits += 64'd32;
            absorb_word(it.data_word);
            return;
        end
        nbytes = (it.byte_count > 3'd4) ? 4 : int'(it.byte_count);
        message_len_bits += 64'(nbytes * 8);
        if (nbytes == 4) begin
            absorb_word(it.data_word);
            absorb_word(MARKER_WORD);
        end else begin
            keep = (nbytes == 0) ? 32'h0 : (32'hffff_ffff << (32 - 8 * nbytes));
            absorb_word((it.data_word & keep) | (32'h80 << (24 - 8 * nbytes)));
        end
        // No room left for the length: flush this block and start another.
        if (block_fill > 14) begin
            while (block_fill != 0) absorb_word(32'h0);
        end
        while (block_fill < 14) absorb_word(32'h0);
        absorb_word(message_len_bits[63:32]);
        absorb_word(message_len_bits[31:0]);
        for (i = 0; i < 8; i++)
            expected_digest.push_back('{hash_chain[i], 3'(i), i == 7});
        restart_hasher();
    endfunction

    // ------------------------------------------------------------------
    // Flow control
    // ------------------------------------------------------------------
    function automatic int sender_gap_pct(input idle_phase_t p);
        case (p)
            PH_SENDER_GAPS: return 56;
            PH_BOTH_IDLE:   return 7;
            default:        return 0;
        endcase
    endfunction

    function automatic int receiver_stall_pct(input idle_phase_t p);
        case (p)
            PH_RECEIVER_STALLS: return 56;
            PH_BOTH_IDLE:       return 7;
            default:            return 0;
        endcase
    endfunction

    // Driver: an accepted item goes to the predictor, then the next item
    // (if any, and unless the sender idles this cycle) is put on the bus.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            restart_hasher();
        end else begin
            if (s_tvalid && s_tready)
                hash_item(offered_word);
            if (!s_tvalid || s_tready) begin
                if (pending_words.size() != 0 &&
                    $urandom_range(99) >= sender_gap_pct(idle_phase)) begin
                    offered_word = pending_words.pop_front();
                    s_tdata  <= {{(shs_pkg::TDATA_W - 35){1'b0}},
                                 offered_word.byte_count, offered_word.data_word};
                    s_tlast  <= offered_word.last_item;
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off in the back-pressure phase
    // that starts when the first digest word of that phase shows up.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready  <= 1'b0;
            hold_left <= 0;
            hold_used <= 1'b0;
        end else if (hold_left != 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (idle_phase == PH_LONG_HOLD && !hold_used && m_tvalid) begin
            m_tready  <= 1'b0;
            hold_left <= LONG_HOLD;
            hold_used <= 1'b1;
        end else begin
            m_tready <= $urandom_range(99) >= receiver_stall_pct(idle_phase);
        end
    end

    // Monitor: every digest word taken is checked against the oldest expectation.
    always @(posedge aclk) begin
        digest_word_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_digest.size() == 0) begin
                $error("digest word %h (index %0d) arrived with none expected",
                       m_tdata[31:0], m_tdata[34:32]);
                fail_count++;
            end else begin
                want = expected_digest.pop_front();
                if (m_tdata[31:0] !== want.digest_word) begin
                    $error("digest_word: expected %h, got %h", want.digest_word, m_tdata[31:0]);
                    fail_count++;
                end
                if (m_tdata[34:32] !== want.word_index) begin
                    $error("word_index: expected %0d, got %0d", want.word_index, m_tdata[34:32]);
                    fail_count++;
                end
                if (m_tlast !== want.last_word) begin
                    $error("last_word: expected %b, got %b", want.last_word, m_tlast);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    function automatic logic [31:0] random_word();
        case ($urandom_range(7))
            0:       return 32'h0000_0000;
            1:       return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    task automatic queue_word(input logic [31:0] data, input logic [2:0] count,
                              input logic last);
        pending_words.push_back('{data, count, last});
    endtask

    // Full words carry a random byte count, which the core must ignore.
    task automatic queue_message(input int full_words, input logic [2:0] tail_count);
        int i;
        for (i = 0; i < full_words; i++)
            queue_word(random_word(), 3'($urandom_range(7)), 1'b0);
        queue_word(random_word(), tail_count, 1'b1);
    endtask

    // Many lengths lie around the block boundary, where padding spills over.
    task automatic queue_random_messages(input int target);
        int queued;
        int len;
        queued = 0;
        while (queued < target) begin
            case ($urandom_range(9))
                0, 1, 2, 3, 4: len = $urandom_range(6);
                5, 6, 7:       len = $urandom_range(17, 12);
                8:             len = $urandom_range(33, 28);
                default:       len = $urandom_range(40);
            endcase
            queue_message(len, 3'($urandom_range(7)));
            queued += len + 1;
        end
    endtask

    task automatic wait_drained();
        do @(posedge aclk);
        while (pending_words.size() != 0 || s_tvalid || expected_digest.size() != 0);
    endtask

    initial begin
        int k;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Empty message: a final item with no valid bytes.
        queue_word(32'hffff_ffff, 3'd0, 1'b1);
        // One-word messages with every tail count; trailing bytes must be masked,
        // four valid bytes push the marker into a word of its own, and counts
        // above four behave as four.
        for (k = 1; k < 8; k++)
            queue_word((k < 4) ? 32'hffff_ffff : 32'h6162_6364, 3'(k), 1'b1);
        // Thirteen full words plus a full tail word leave no room for the
        // length, so a second padding block is needed.
        for (k = 0; k < 13; k++)
            queue_word((k % 2) ? 32'hffff_ffff : 32'h0000_0000, 3'd7, 1'b0);
        queue_word(32'h0000_0000, 3'd4, 1'b1);
        wait_drained();

        for (k = 0; k < 5; k++) begin
            @(posedge aclk);
            idle_phase <= RANDOM_PHASES[k];
            queue_random_messages(PHASE_ITEMS);
            wait_drained();
        end

        repeat (END_SETTLE) @(posedge aclk);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
`default_nettype wire
